// File: src/vtpd_pkg.sv
package vtpd_pkg;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_XFORM = 1'b1;

	typedef struct packed {
		logic               action;
		logic [3:0]         coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               w_zero;
	} res_t;

endpackage

// File: src/vertex_transform_perspective_divide.sv
// Homogeneous 4x4 vertex transform with perspective divide.
// The vtx channel carries one beat per action: a coefficient write
// (action 0) updates the matrix at once and gives no result; a point
// (action 1) is multiplied as a row vector with w = 1 by the matrix and
// the res channel later gives x/w, y/w, z/w saturated to Q16.16, or
// zeros with w_zero set when w is exactly zero.
// Throughput is one beat per cycle while vtx_stall is low. A point passes
// 37 register stages: two for the products and column sums, two for sign
// handling and numerator scaling, one per quotient bit (32 stages of the
// restoring divider), and one for the result register, which drives res.
// Each stage holds its beat until the next one frees, so a stall on res
// fills the bubbles first and then backs up to vtx_stall; nothing is lost
// or repeated. A point accepted right after a write uses the new value.
// Reset clears the pipeline and loads the identity matrix.
module vertex_transform_perspective_divide #(
	parameter int COEF_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vtx_valid,
	output logic           vtx_stall,
	input  vtpd_pkg::vtx_t vtx_data,
	output logic           res_valid,
	input  logic           res_stall,
	output vtpd_pkg::res_t res_data
);
	import vtpd_pkg::*;

	localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
	localparam int SW = 32 + CW + 2;

	logic                 sum_valid;
	logic                 sum_ready;
	logic signed [SW-1:0] sum [4];

	vtpd_xform #(
		.COEF_WIDTH(COEF_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.SW        (SW)
	) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx_data  (vtx_data),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum)
	);

	vtpd_div #(
		.FRAC_BITS(FRAC_BITS),
		.SW       (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// File: src/vtpd_xform.sv
module vtpd_xform #(
	parameter int COEF_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int SW         = 66
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	output logic               vtx_stall,
	input  vtpd_pkg::vtx_t     vtx_data,
	output logic               sum_valid,
	input  logic               sum_ready,
	output logic signed [SW-1:0] sum [4]
);
	import vtpd_pkg::*;

	localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
	localparam int PW = 32 + CW;

	logic signed [CW-1:0] coef_q [16];
	logic signed [PW-1:0] prod_s1 [3][4];
	logic signed [PW-1:0] bias_s1 [4];
	logic                 v_s1, v_s2;
	logic                 en_s1, en_s2;
	logic signed [31:0]   pt [3];

	function automatic logic [CW-1:0] ident_one();
		logic [31:0] one;
		one = 32'(1) << FRAC_BITS;
		return one[CW-1:0];
	endfunction

	assign en_s2     = !v_s2 || sum_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign vtx_stall = !en_s1;
	assign sum_valid = v_s2;

	assign pt[0] = vtx_data.in_x;
	assign pt[1] = vtx_data.in_y;
	assign pt[2] = vtx_data.in_z;

	// Writes land in the matrix at acceptance, so the next point sees them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				coef_q[i] <= (i % 5 == 0) ? signed'(ident_one()) : '0;
			end
		end else if (vtx_valid && en_s1 && vtx_data.action == ACT_WRITE) begin
			coef_q[vtx_data.coef_index] <= vtx_data.coef_value[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= vtx_valid && vtx_data.action == ACT_XFORM;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s1[r][c] <= PW'(pt[r] * coef_q[r*4+c]);
				end
				bias_s1[c] <= PW'(coef_q[12+c]) <<< FRAC_BITS;
			end
		end
		if (en_s2) begin
			for (int c = 0; c < 4; c++) begin
				sum[c] <= SW'(prod_s1[0][c]) + SW'(prod_s1[1][c])
					+ SW'(prod_s1[2][c]) + SW'(bias_s1[c]);
			end
		end
	end

endmodule

// File: src/vtpd_div.sv
module vtpd_div #(
	parameter int FRAC_BITS = 16,
	parameter int SW        = 66
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sum_valid,
	output logic                 sum_ready,
	input  logic signed [SW-1:0] sum [4],
	output logic                 res_valid,
	input  logic                 res_stall,
	output vtpd_pkg::res_t       res_data
);
	import vtpd_pkg::*;

	localparam int QB = 32;
	localparam int RW = SW + FRAC_BITS + QB;
	localparam int NS = QB + 3;

	logic [NS-1:0] v;
	logic [NS-1:0] en;

	logic [SW-1:0] mag_s3 [3];
	logic [SW-1:0] den_s3;
	logic [2:0]    neg_s3;
	logic          wz_s3;

	logic [RW-1:0] rem_sd [QB+1][3];
	logic [RW-1:0] den_sd [QB+1];
	logic [QB-1:0] quo_sd [QB+1][3];
	logic [2:0]    neg_sd [QB+1];
	logic [2:0]    sat_sd [QB+1];
	logic          wz_sd  [QB+1];

	res_t res_q;

	assign en[NS-1] = !v[NS-1] || !res_stall;
	genvar k;
	generate
		for (k = 0; k < NS-1; k++) begin : g_en
			assign en[k] = !v[k] || en[k+1];
		end
	endgenerate
	assign sum_ready = en[0];
	assign res_valid = v[NS-1];
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0]) begin
				v[0] <= sum_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					v[i] <= v[i-1];
				end
			end
		end
	end

	// Signs and magnitudes.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < 3; l++) begin
				mag_s3[l] <= sum[l][SW-1] ? SW'(-sum[l]) : SW'(sum[l]);
				neg_s3[l] <= sum[l][SW-1] ^ sum[3][SW-1];
			end
			den_s3 <= sum[3][SW-1] ? SW'(-sum[3]) : SW'(sum[3]);
			wz_s3  <= (sum[3] == '0);
		end
	end

	// Scale the numerator and flag quotients that cannot fit in 32 bits.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < 3; l++) begin
				rem_sd[0][l] <= RW'(mag_s3[l]) << FRAC_BITS;
				quo_sd[0][l] <= '0;
				sat_sd[0][l] <= (RW'(mag_s3[l]) << FRAC_BITS) >= (RW'(den_s3) << QB);
			end
			den_sd[0] <= RW'(den_s3);
			neg_sd[0] <= neg_s3;
			wz_sd[0]  <= wz_s3;
		end
	end

	// One quotient bit per stage, most significant first.
	genvar j;
	generate
		for (j = 1; j <= QB; j++) begin : g_bit
			logic [RW-1:0] dsh;
			logic [2:0]    ge;
			always_comb begin
				dsh = den_sd[j-1] << (QB - j);
				for (int l = 0; l < 3; l++) begin
					ge[l] = rem_sd[j-1][l] >= dsh;
				end
			end
			always_ff @(posedge clk) begin
				if (en[1+j]) begin
					for (int l = 0; l < 3; l++) begin
						rem_sd[j][l] <= ge[l] ? rem_sd[j-1][l] - dsh : rem_sd[j-1][l];
						quo_sd[j][l] <= quo_sd[j-1][l] | (QB'(ge[l]) << (QB - j));
					end
					den_sd[j] <= den_sd[j-1];
					neg_sd[j] <= neg_sd[j-1];
					sat_sd[j] <= sat_sd[j-1];
					wz_sd[j]  <= wz_sd[j-1];
				end
			end
		end
	endgenerate

	function automatic logic [31:0] finish(logic [QB-1:0] q, logic neg, logic sat);
		logic [31:0] r;
		if (!neg) begin
			r = (sat || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
		end else begin
			r = (sat || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			if (wz_sd[QB]) begin
				res_q.out_x  <= '0;
				res_q.out_y  <= '0;
				res_q.out_z  <= '0;
				res_q.w_zero <= 1'b1;
			end else begin
				res_q.out_x  <= finish(quo_sd[QB][0], neg_sd[QB][0], sat_sd[QB][0]);
				res_q.out_y  <= finish(quo_sd[QB][1], neg_sd[QB][1], sat_sd[QB][1]);
				res_q.out_z  <= finish(quo_sd[QB][2], neg_sd[QB][2], sat_sd[QB][2]);
				res_q.w_zero <= 1'b0;
			end
		end
	end

endmodule
